/* sv/effect_loop_preset_switcher_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the effect loop preset switcher
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef EFFECT_LOOP_PRESET_SWITCHER_MACROS_SVH
`define EFFECT_LOOP_PRESET_SWITCHER_MACROS_SVH

// same-cycle implication
`define ELPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ELPS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/elps_pkg.sv */
// ----------------------------------------------------------------------------
// Effect loop preset switcher package
// Shared constants and types.
// ----------------------------------------------------------------------------
package elps_pkg;

  localparam int unsigned NUM_PRESETS_DEF = 5;

  localparam logic KIND_SWITCH = 1'b0;
  localparam logic KIND_POT    = 1'b1;

  localparam logic REG_POT_LOW  = 1'b0;
  localparam logic REG_POT_HIGH = 1'b1;

  localparam logic [7:0] POT_LOW_RST  = 8'd31;
  localparam logic [7:0] POT_HIGH_RST = 8'd240;
  localparam logic [7:0] PORT_A_RST   = 8'hFB;
  localparam logic [7:0] PORT_B_RST   = 8'hFF;
  localparam logic [15:0] PRESET_ERASED = 16'hFFFF;

  localparam int unsigned SW_BYPASS = 0;
  localparam int unsigned SW_SET    = 6;
  localparam int unsigned SW_MODE   = 7;

  localparam logic [7:0] ARMED_MASK   = 8'h3F;
  localparam logic [7:0] PA_PROG_MASK = 8'b0000_0011;
  localparam logic [7:0] PB_PROG_MASK = 8'b0000_0111;
  localparam logic [7:0] PA_SET_LED   = 8'b0000_0100;

  localparam logic [1:0] DELAY_BOTH   = 2'b11;
  localparam logic [1:0] DELAY_FIRST  = 2'b01;
  localparam logic [1:0] DELAY_SECOND = 2'b10;

  typedef struct packed {
    logic       playing;
    logic       relay;
    logic [7:0] port_a;
    logic [7:0] port_b;
    logic       armed;
    logic [1:0] delay;
  } elps_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] switches;
    logic [7:0] pot_level;
  } elps_item_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  slot;
    logic [15:0] data;
  } elps_store_wr_t;

endpackage

/* sv/elps_if.sv */
// ----------------------------------------------------------------------------
// Effect loop preset switcher channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface elps_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] switches;
  logic [7:0] pot_level;

  modport source(output valid, kind, switches, pot_level, input ready);
  modport sink(input valid, kind, switches, pot_level, output ready);
endinterface

interface elps_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_a;
  logic [7:0] port_b;
  logic       bypass_relay;
  logic [1:0] delay_select;
  logic       save_armed;

  modport source(output valid, port_a, port_b, bypass_relay, delay_select, save_armed,
                 input ready);
  modport sink(input valid, port_a, port_b, bypass_relay, delay_select, save_armed,
               output ready);
endinterface

/* sv/effect_loop_preset_switcher.sv */
// ----------------------------------------------------------------------------
// Effect loop preset switcher
// Footswitch controller for five effect loops with stored presets.
// ----------------------------------------------------------------------------
// channel | dir | transfer carries
// item    | in  | kind, switches, pot_level
// result  | out | port_a, port_b, bypass_relay, delay_select, save_armed
// cfg     | in  | cfg_we, cfg_index, cfg_data (thresholds)
//
// One item per cycle unless the result stalls; a result passes the item register, then the state register.
// The item register feeds one pass of update logic into the state register,
// which is the result register.
// Reset is synchronous: thresholds, state and preset store return to defaults.
// A stalled result holds; one more item waits in the item register.
// ----------------------------------------------------------------------------
module effect_loop_preset_switcher #(
  parameter int unsigned NUM_PRESETS = elps_pkg::NUM_PRESETS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [7:0]  cfg_data,
  elps_item_if.sink     item,
  elps_result_if.source result
);
  import elps_pkg::*;

  logic [7:0]  pot_low;
  logic [7:0]  pot_high;
  logic        s1_valid;
  elps_item_t  s1_item;
  logic        out_valid;
  elps_state_t state;
  elps_state_t state_next;
  elps_store_wr_t store_wr;
  logic [NUM_PRESETS-1:0][15:0] store;
  logic        advance;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pot_low  <= POT_LOW_RST;
      pot_high <= POT_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POT_LOW:  pot_low  <= cfg_data;
        REG_POT_HIGH: pot_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_item <= '{kind: item.kind, switches: item.switches, pot_level: item.pot_level};
    end
  end

  elps_update #(
    .NUM_PRESETS(NUM_PRESETS)
  ) u_update (
    .state      (state),
    .item       (s1_item),
    .pot_low    (pot_low),
    .pot_high   (pot_high),
    .store      (store),
    .state_next (state_next),
    .store_wr   (store_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      state.playing <= 1'b0;
      state.relay   <= 1'b0;
      state.port_a  <= PORT_A_RST;
      state.port_b  <= PORT_B_RST;
      state.armed   <= 1'b0;
      state.delay   <= 2'b00;
    end else if (advance) begin
      out_valid <= 1'b1;
      state     <= state_next;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PRESETS; i++) store[i] <= PRESET_ERASED;
    end else if (advance && store_wr.we) begin
      for (int i = 0; i < NUM_PRESETS; i++) begin
        if (store_wr.slot == 3'(i + 1)) store[i] <= store_wr.data;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.port_a       = state.port_a;
  assign result.port_b       = state.port_b;
  assign result.bypass_relay = state.relay;
  assign result.delay_select = state.delay;
  assign result.save_armed   = state.armed;

endmodule

/* sv/elps_update.sv */
// ----------------------------------------------------------------------------
// Effect loop preset switcher update logic
// Next state and preset write for one registered item.
// ----------------------------------------------------------------------------
module elps_update #(
  parameter int unsigned NUM_PRESETS = elps_pkg::NUM_PRESETS_DEF
) (
  input  elps_pkg::elps_state_t              state,
  input  elps_pkg::elps_item_t               item,
  input  logic [7:0]                         pot_low,
  input  logic [7:0]                         pot_high,
  input  logic [NUM_PRESETS-1:0][15:0]       store,
  output elps_pkg::elps_state_t              state_next,
  output elps_pkg::elps_store_wr_t           store_wr
);
  import elps_pkg::*;

  logic [7:0]  pressed;
  logic [2:0]  k;
  logic [2:0]  rslot;
  logic [15:0] rdata;

  always_comb begin
    pressed = ~item.switches;
    k = 3'd0;
    for (int i = 5; i >= 1; i--) begin
      if (pressed[i]) k = 3'(i);
    end
    rslot = (k != 3'd0) ? k : 3'd1;
    rdata = PRESET_ERASED;
    for (int i = 0; i < NUM_PRESETS; i++) begin
      if (rslot == 3'(i + 1)) rdata = store[i];
    end
  end

  always_comb begin
    logic       do_recall;
    logic [7:0] bitm;
    elps_state_t ns;
    elps_store_wr_t wr;
    ns = state;
    wr.we = 1'b0;
    wr.slot = k;
    wr.data = {state.port_b, state.port_a};
    do_recall = 1'b0;
    bitm = 8'd1 << (k + 3'd2);
    if (item.kind == KIND_POT) begin
      if (item.pot_level < pot_low) ns.delay = DELAY_BOTH;
      if (item.pot_level >= pot_low && item.pot_level < pot_high) ns.delay = DELAY_FIRST;
      if (item.pot_level >= pot_high) ns.delay = DELAY_SECOND;
    end else if (pressed != 8'd0) begin
      if (state.armed) begin
        if ((pressed & ARMED_MASK) != 8'd0) begin
          ns.port_a = state.port_a | PA_PROG_MASK;
          ns.port_b = state.port_b | PB_PROG_MASK;
          wr.we = (k != 3'd0) && (32'(k) <= NUM_PRESETS);
          wr.data = {ns.port_b, ns.port_a};
          ns.armed = 1'b0;
        end
      end else if (pressed[SW_BYPASS]) begin
        ns.relay = ~state.relay;
      end else if (!pressed[SW_MODE] && pressed[SW_SET] && !state.playing) begin
        ns.port_a = state.port_a & ~PA_PROG_MASK;
        ns.port_b = state.port_b & ~PB_PROG_MASK;
        ns.armed = 1'b1;
      end else begin
        if (pressed[SW_MODE]) begin
          if (state.playing) begin
            ns.port_a = (state.port_a | PA_PROG_MASK) & ~PA_SET_LED;
            ns.port_b = state.port_b | PB_PROG_MASK;
            ns.playing = 1'b0;
          end else begin
            ns.playing = 1'b1;
          end
        end
        if (!ns.playing) begin
          if (k != 3'd0) begin
            if ((ns.port_b & bitm) == 8'd0) begin
              ns.port_b = ns.port_b | bitm;
              ns.port_a = ns.port_a | bitm;
            end else begin
              ns.port_b = ns.port_b & ~bitm;
              ns.port_a = ns.port_a & ~bitm;
            end
          end
        end else begin
          ns.port_a = ns.port_a | PA_PROG_MASK;
          ns.port_b = ns.port_b | PB_PROG_MASK;
          do_recall = (k != 3'd0) || pressed[SW_MODE];
        end
      end
    end
    if (do_recall) begin
      ns.port_a = rdata[7:0];
      ns.port_b = rdata[15:8];
      if (rslot <= 3'd3) ns.port_b = ns.port_b & ~(8'd1 << (rslot - 3'd1));
      else ns.port_a = ns.port_a & ~(8'd1 << (rslot - 3'd4));
      ns.port_a = ns.port_a | PA_SET_LED;
    end
    state_next = ns;
    store_wr = wr;
  end

endmodule

/* sv/elps_checker.sv */
// ----------------------------------------------------------------------------
// Effect loop preset switcher checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "effect_loop_preset_switcher_macros.svh"

module elps_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] port_a,
  input logic [7:0] port_b,
  input logic       bypass_relay,
  input logic [1:0] delay_select,
  input logic       save_armed
);

  `ELPS_ASSERT_NXT(a_result_hold, clk, rst,
    result_valid && !result_ready,
    result_valid && $stable(port_a) && $stable(port_b) && $stable(bypass_relay) &&
      $stable(delay_select) && $stable(save_armed),
    "stalled result changed")

  // item register, then result register
  `ELPS_ASSERT_NXT(a_item_to_result, clk, rst,
    $past(item_valid && item_ready && !result_valid), result_valid,
    "result missing after item transfer")

  `ELPS_ASSERT_IMP(a_stall_only_on_result, clk, rst,
    !item_ready, result_valid && !result_ready,
    "item stalled without result stall")

  `ELPS_ASSERT_IMP(a_armed_leds, clk, rst,
    result_valid && save_armed, port_a[2:0] == 3'b000 && port_b[2:0] == 3'b000,
    "armed without program and set LEDs lit")

endmodule

bind effect_loop_preset_switcher elps_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .port_a       (result.port_a),
  .port_b       (result.port_b),
  .bypass_relay (result.bypass_relay),
  .delay_select (result.delay_select),
  .save_armed   (result.save_armed)
);
